>>> sv/fbst_pkg.sv
`default_nettype none

package fbst_pkg;

    // Text slots of one value, lowest slot is sent first
    localparam int unsigned SLOTS   = 13;
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [1:0] FRAC_DIGITS_RESET = 2'd3;

    // Slot positions of a finite value
    localparam int unsigned SLOT_SIGN  = 0;
    localparam int unsigned SLOT_LEAD  = 1;
    localparam int unsigned SLOT_POINT = 2;
    localparam int unsigned SLOT_FRAC0 = 3;
    localparam int unsigned SLOT_FRAC1 = 4;
    localparam int unsigned SLOT_FRAC2 = 5;
    localparam int unsigned SLOT_X     = 6;
    localparam int unsigned SLOT_TWO   = 7;
    localparam int unsigned SLOT_CARET = 8;
    localparam int unsigned SLOT_ESIGN = 9;
    localparam int unsigned SLOT_EHUN  = 10;
    localparam int unsigned SLOT_ETEN  = 11;
    localparam int unsigned SLOT_EONE  = 12;

    typedef logic [7:0] char_t;

    // ASCII codes
    localparam char_t CH_MINUS = 8'h2d;
    localparam char_t CH_POINT = 8'h2e;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_ONE   = 8'h31;
    localparam char_t CH_TWO   = 8'h32;
    localparam char_t CH_CARET = 8'h5e;
    localparam char_t CH_X     = 8'h78;
    localparam char_t CH_UP_N  = 8'h4e;
    localparam char_t CH_LO_A  = 8'h61;
    localparam char_t CH_UP_I  = 8'h49;
    localparam char_t CH_LO_N  = 8'h6e;
    localparam char_t CH_LO_F  = 8'h66;

    // One formatted value: a character per slot and which slots are sent
    typedef struct packed {
        logic [SLOTS-1:0]  mask;
        char_t [SLOTS-1:0] chars;
    } desc_t;

endpackage

`default_nettype wire

>>> sv/float_to_binary_sci_text.sv
// Path: an input value passes the front stage register, the queue, then the output character register.
// Throughput: one character per cycle while m_tready is high; a value prints 3 to 13 characters,
//   which all leave through the single output character register.
// A four-entry queue lets the input side take further values while text is being sent.
// Reset (aresetn low, synchronous): clears all valid state and sets fraction_digits to 3.
`default_nettype none

module float_to_binary_sci_text (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // [31:0] float_bits
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] character
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data    // fraction_digits
);
    import fbst_pkg::*;

    logic [1:0] frac_digits_reg;
    logic       f_valid, f_ready;
    desc_t      f_desc;
    logic       q_valid, q_ready;
    desc_t      q_desc;

    // Hold the configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_digits_reg <= FRAC_DIGITS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            frac_digits_reg <= cfg_data;
        end
    end

    fbst_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .frac_digits (frac_digits_reg),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_desc    (f_desc)
    );

    fbst_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_desc   (f_desc),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_desc  (q_desc)
    );

    fbst_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_desc  (q_desc),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> sv/fbst_front.sv
`default_nettype none

module fbst_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [31:0]    s_tdata,
    input  wire logic [1:0]     frac_digits,
    output logic                out_valid,
    input  wire logic           out_ready,
    output fbst_pkg::desc_t     out_desc
);
    import fbst_pkg::*;

    typedef struct packed {
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } dec_t;

    function automatic logic [9:0] pow10(input logic [1:0] d);
        logic [9:0] p;
        unique case (d)
            2'd0: p = 10'd1;
            2'd1: p = 10'd10;
            2'd2: p = 10'd100;
            default: p = 10'd1000;
        endcase
        return p;
    endfunction

    // Split a value below 1000 into decimal digits
    function automatic dec_t split_dec(input logic [9:0] val);
        dec_t r;
        logic [6:0] rem;
        r = '0;
        for (int k = 1; k < 10; k++) begin
            if (val >= 10'(k * 100)) r.hund = 4'(k);
        end
        rem = 7'(val - 10'(r.hund) * 10'd100);
        for (int k = 1; k < 10; k++) begin
            if (rem >= 7'(k * 10)) r.tens = 4'(k);
        end
        r.ones = 4'(rem - 7'(r.tens) * 7'd10);
        return r;
    endfunction

    function automatic char_t dig(input logic [3:0] v);
        return CH_ZERO + {4'b0, v};
    endfunction

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_sign_reg;
    logic [7:0]  s1_bexp_reg;
    logic        s1_mant_nz_reg;
    logic [9:0]  s1_v_reg;
    logic [1:0]  s1_d_reg;

    logic [18:0] prod;
    logic        carry, denormal, is_nan, is_zero, is_inf;
    logic [8:0]  ev;
    logic        eneg;
    logic [7:0]  eabs;
    dec_t        vd, ed;
    logic [3:0]  fh, ft, fo;
    desc_t       desc;

    // Scaled and rounded fraction: (m9 * 10^d + 256) / 512
    always_comb begin
        prod = 19'(s_tdata[22:14]) * 19'(pow10(frac_digits)) + 19'd256;
    end

    assign s_tready      = !s1_valid_reg || out_ready;
    assign s1_valid_next = s_tready ? s_tvalid : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture the beat's fields
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_sign_reg    <= s_tdata[31];
            s1_bexp_reg    <= s_tdata[30:23];
            s1_mant_nz_reg <= (s_tdata[22:0] != 23'd0);
            s1_v_reg       <= prod[18:9];
            s1_d_reg       <= frac_digits;
        end
    end

    // Classify and split into digits
    always_comb begin
        denormal = (s1_bexp_reg == 8'd0);
        is_nan   = (s1_bexp_reg == 8'hff) && s1_mant_nz_reg;
        is_zero  = denormal && !s1_mant_nz_reg;
        is_inf   = (s1_bexp_reg == 8'hff) && !s1_mant_nz_reg;
        carry    = (s1_d_reg != 2'd0) && (s1_v_reg == pow10(s1_d_reg));
        vd       = split_dec(s1_v_reg);
        fh       = carry ? 4'd0 : vd.hund;
        ft       = carry ? 4'd0 : vd.tens;
        fo       = carry ? 4'd0 : vd.ones;
        ev       = {1'b0, s1_bexp_reg} + {8'b0, carry};
        eneg     = denormal || (ev < 9'd127);
        if (denormal) begin
            eabs = 8'd126;
        end else if (ev < 9'd127) begin
            eabs = 8'(9'd127 - ev);
        end else begin
            eabs = 8'(ev - 9'd127);
        end
        ed = split_dec({2'b0, eabs});
    end

    // Fill the text slots
    always_comb begin
        desc = '0;
        priority if (is_nan) begin
            desc.chars[0] = CH_UP_N;
            desc.chars[1] = CH_LO_A;
            desc.chars[2] = CH_UP_N;
            desc.mask[2:0] = 3'b111;
        end else if (is_zero) begin
            desc.chars[0] = CH_ZERO;
            desc.chars[1] = CH_POINT;
            desc.chars[2] = CH_ZERO;
            desc.mask[2:0] = 3'b111;
        end else if (is_inf) begin
            if (s1_sign_reg) begin
                desc.chars[0] = CH_MINUS;
                desc.chars[1] = CH_UP_I;
                desc.chars[2] = CH_LO_N;
                desc.chars[3] = CH_LO_F;
                desc.mask[3:0] = 4'b1111;
            end else begin
                desc.chars[0] = CH_UP_I;
                desc.chars[1] = CH_LO_N;
                desc.chars[2] = CH_LO_F;
                desc.mask[2:0] = 3'b111;
            end
        end else begin
            desc.chars[SLOT_SIGN]  = CH_MINUS;
            desc.mask[SLOT_SIGN]   = s1_sign_reg;
            desc.chars[SLOT_LEAD]  = (denormal && !carry) ? CH_ZERO : CH_ONE;
            desc.mask[SLOT_LEAD]   = 1'b1;
            desc.chars[SLOT_POINT] = CH_POINT;
            desc.mask[SLOT_POINT]  = 1'b1;
            unique case (s1_d_reg)
                2'd3: begin
                    desc.chars[SLOT_FRAC0] = dig(fh);
                    desc.chars[SLOT_FRAC1] = dig(ft);
                    desc.chars[SLOT_FRAC2] = dig(fo);
                    desc.mask[SLOT_FRAC0]  = 1'b1;
                    desc.mask[SLOT_FRAC1]  = 1'b1;
                    desc.mask[SLOT_FRAC2]  = 1'b1;
                end
                2'd2: begin
                    desc.chars[SLOT_FRAC0] = dig(ft);
                    desc.chars[SLOT_FRAC1] = dig(fo);
                    desc.mask[SLOT_FRAC0]  = 1'b1;
                    desc.mask[SLOT_FRAC1]  = 1'b1;
                end
                2'd1: begin
                    desc.chars[SLOT_FRAC0] = dig(fo);
                    desc.mask[SLOT_FRAC0]  = 1'b1;
                end
                default: begin
                end
            endcase
            desc.chars[SLOT_X]     = CH_X;
            desc.chars[SLOT_TWO]   = CH_TWO;
            desc.chars[SLOT_CARET] = CH_CARET;
            desc.mask[SLOT_X]      = 1'b1;
            desc.mask[SLOT_TWO]    = 1'b1;
            desc.mask[SLOT_CARET]  = 1'b1;
            desc.chars[SLOT_ESIGN] = CH_MINUS;
            desc.mask[SLOT_ESIGN]  = eneg;
            desc.chars[SLOT_EHUN]  = dig(ed.hund);
            desc.mask[SLOT_EHUN]   = (eabs >= 8'd100);
            desc.chars[SLOT_ETEN]  = dig(ed.tens);
            desc.mask[SLOT_ETEN]   = (eabs >= 8'd10);
            desc.chars[SLOT_EONE]  = dig(ed.ones);
            desc.mask[SLOT_EONE]   = 1'b1;
        end
    end

    assign out_valid = s1_valid_reg;
    assign out_desc  = desc;

endmodule

`default_nettype wire

>>> sv/fbst_queue.sv
`default_nettype none

module fbst_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire fbst_pkg::desc_t  in_desc,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output fbst_pkg::desc_t       out_desc
);
    import fbst_pkg::*;

    desc_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_desc  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers with wrap, track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_desc;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue fill level out of range");

    a_push_only_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue push lost");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty state");

endmodule

`default_nettype wire

>>> sv/fbst_back.sv
`default_nettype none

module fbst_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire fbst_pkg::desc_t  in_desc,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);
    import fbst_pkg::*;

    logic             busy_reg, busy_next;
    logic [SLOTS-1:0] rem_reg, rem_next;
    logic             out_valid_reg, out_valid_next;
    char_t            out_char_reg;
    logic             out_last_reg;

    logic [SLOTS-1:0] cur_mask, low, rest;
    logic             out_free, emit;
    char_t            ch;

    // Pick the lowest slot still to send
    assign cur_mask = busy_reg ? rem_reg : in_desc.mask;
    assign low      = cur_mask & (~cur_mask + 1'b1);
    assign rest     = cur_mask & ~low;
    assign out_free = !out_valid_reg || m_tready;
    assign emit     = in_valid && out_free;
    assign in_ready = emit && (rest == '0);

    always_comb begin
        ch = '0;
        for (int i = 0; i < SLOTS; i++) begin
            ch = ch | (low[i] ? in_desc.chars[i] : '0);
        end
    end

    // Drop sent slots, release the entry when its last character is loaded
    always_comb begin
        busy_next      = busy_reg;
        rem_next       = rem_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        if (emit) begin
            busy_next      = (rest != '0);
            rem_next       = rest;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        if (emit) begin
            out_char_reg <= ch;
            out_last_reg <= (rest == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    a_entry_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> (cur_mask != '0))
        else $error("queued value has no characters");

    a_one_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> $onehot(low))
        else $error("more than one slot selected");

    a_busy_holds_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> in_valid)
        else $error("entry vanished in the middle of its text");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import fbst_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned PHASE_ITEMS  = 54;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam logic [7:0]  EXP_SPECIAL  = 8'hff;

    // One expected character of the text stream
    typedef struct packed {
        char_t ch;
        logic  last;
    } text_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;    // [31:0] float_bits
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] character
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = '0;    // fraction_digits

    logic [31:0] pending_floats[$];
    text_beat_t  expected_text[$];
    logic [1:0]  digits_setting = FRAC_DIGITS_RESET;
    int          fail_count     = 0;

    float_to_binary_sci_text u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Format one float as text and queue its characters
    function automatic void predict_text(input logic [31:0] bits, input logic [1:0] digits);
        logic        sign;
        logic [7:0]  bexp;
        logic [22:0] mant;
        int unsigned t;
        int unsigned r;
        int unsigned tenpow;
        int unsigned a;
        int          e;
        logic        carry;
        logic        denormal;
        char_t       frac[3];
        char_t       line_q[$];
        sign     = bits[31];
        bexp     = bits[30:23];
        mant     = bits[22:0];
        carry    = 1'b0;
        denormal = (bexp == 8'd0);
        tenpow   = 1;
        frac     = '{CH_ZERO, CH_ZERO, CH_ZERO};
        if (bexp == EXP_SPECIAL && mant != 0) begin
            line_q = '{CH_UP_N, CH_LO_A, CH_UP_N};
        end else if (bexp == 8'd0 && mant == 0) begin
            line_q = '{CH_ZERO, CH_POINT, CH_ZERO};
        end else if (bexp == EXP_SPECIAL) begin
            if (sign)
                line_q.push_back(CH_MINUS);
            line_q.push_back(CH_UP_I);
            line_q.push_back(CH_LO_N);
            line_q.push_back(CH_LO_F);
        end else begin
            // Round the top nine mantissa bits to the chosen digit count
            if (digits != 0 && mant != 0) begin
                t = int'(mant[22:14]) * 1953125;
                for (int i = digits; i < 8; i++)
                    t = t / 10;
                for (int i = 0; i <= digits; i++)
                    tenpow = tenpow * 10;
                r = t % 10;
                if (r >= 5) begin
                    t = t + 10 - r;
                    if (t == tenpow)
                        carry = 1'b1;
                end
                if (!carry) begin
                    t = t / 10;
                    for (int i = digits; i > 0; i--) begin
                        frac[i-1] = CH_ZERO + char_t'(t % 10);
                        t = t / 10;
                    end
                end
            end
            if (sign)
                line_q.push_back(CH_MINUS);
            line_q.push_back((denormal && !carry) ? CH_ZERO : CH_ONE);
            line_q.push_back(CH_POINT);
            for (int i = 0; i < digits; i++)
                line_q.push_back(frac[i]);
            line_q.push_back(CH_X);
            line_q.push_back(CH_TWO);
            line_q.push_back(CH_CARET);
            // Denormals keep the fixed minimum exponent
            if (denormal) begin
                e = -126;
            end else begin
                e = int'(bexp) - 127 + int'(carry);
            end
            if (e < 0) begin
                line_q.push_back(CH_MINUS);
                a = -e;
            end else begin
                a = e;
            end
            if (a >= 100)
                line_q.push_back(CH_ZERO + char_t'(a / 100));
            if (a >= 10)
                line_q.push_back(CH_ZERO + char_t'((a / 10) % 10));
            line_q.push_back(CH_ZERO + char_t'(a % 10));
        end
        foreach (line_q[i])
            expected_text.push_back('{ch: line_q[i], last: (i == line_q.size() - 1)});
    endfunction

    // Draw a float pattern, biased toward specials, denormals and rounding edges
    function automatic logic [31:0] random_float();
        logic [31:0] bits;
        logic [7:0]  bexp;
        bits = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                bits[30:23] = ($urandom_range(0, 1) == 0) ? 8'd0 : EXP_SPECIAL;
                if ($urandom_range(0, 1) == 0)
                    bits[22:0] = '0;
            end
            1: begin
                bits[30:23] = 8'd0;
                if ($urandom_range(0, 1) == 0)
                    bits[22:0] = 23'($urandom_range(1, 16383));
            end
            2: begin
                bits[22:14] = 9'($urandom_range(480, 511));
                bits[30:23] = 8'($urandom_range(0, 254));
            end
            3: begin
                bits[22:14] = '0;
            end
            4: begin
                case ($urandom_range(0, 6))
                    0:       bexp = 8'd1;
                    1:       bexp = 8'd2;
                    2:       bexp = 8'd126;
                    3:       bexp = 8'd127;
                    4:       bexp = 8'd128;
                    5:       bexp = 8'd253;
                    default: bexp = 8'd254;
                endcase
                bits[30:23] = bexp;
            end
            default: ;
        endcase
        return bits;
    endfunction

    // Feed floats in bursts with random gaps; hold a beat until taken
    int burst_left = 8;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_text(s_tdata, digits_setting);
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_floats.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_floats.pop_front();
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check each character beat against the oldest expectation; stall in windows
    int pattern_cnt = 0;
    int stall_mode  = 0;

    always @(posedge aclk) begin
        text_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    $error("character: unexpected beat 0x%02h, nothing expected", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.ch) begin
                        $error("character: expected 0x%02h, got 0x%02h", want.ch, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            pattern_cnt = pattern_cnt + 1;
            if (pattern_cnt % 48 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 0);
                2:       m_tready <= (pattern_cnt % 3 == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // End the run when no beat moves on any channel for too long
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("float_to_binary_sci_text verification failed");
                $finish;
            end
        end
    end

    // Write fraction_digits; only called with the block idle
    task automatic write_digits(input logic [1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        digits_setting = value;
        cfg_valid <= 1'b0;
    endtask

    // Hold off until every queued float is taken and its text has come out
    task automatic drain();
        do
            @(negedge aclk);
        while (pending_floats.size() != 0 || s_tvalid || expected_text.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    logic [31:0] directed_floats[] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
        32'h7fc0_0000, 32'hffff_ffff, 32'h7f80_0001, 32'h3f80_0000,
        32'hbfc0_0000, 32'h7f7f_ffff, 32'hff7f_c000, 32'h0080_0000,
        32'h0000_0001, 32'h007f_ffff, 32'h8040_0000, 32'h4000_3fff,
        32'h0d00_0000, 32'h3fff_c000, 32'h4220_0000, 32'h3f00_4000
    };

    logic [1:0] digit_plan[] = '{2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2};

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed values at the reset digit count
        @(negedge aclk);
        foreach (directed_floats[i])
            pending_floats.push_back(directed_floats[i]);
        drain();

        // Random phases across every digit count
        foreach (digit_plan[p]) begin
            write_digits(digit_plan[p]);
            @(negedge aclk);
            repeat (PHASE_ITEMS)
                pending_floats.push_back(random_float());
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (expected_text.size() != 0) begin
            $error("character: %0d expected beats never arrived", expected_text.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("float_to_binary_sci_text verification clean");
        end else begin
            $display("float_to_binary_sci_text verification failed");
        end
        $finish;
    end

endmodule
